[hw/rtl/lagl_pkg.sv]
// Shared types, constants and arithmetic helpers of the lidar angle ground labeler.
package lagl_pkg;

    // Ring limit of the sensor and default CORDIC length
    localparam int MAX_RINGS        = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // Integer square root: 40-bit radicand, two result bits per cycle
    localparam int RAD_W    = 40;
    localparam int ROOT_W   = 20;
    localparam int REM_W    = 22;
    localparam int SQRT_CYC = RAD_W / 4;

    // CORDIC datapath widths
    localparam int XY_W   = 38;
    localparam int ANG_W  = 23;
    localparam int FRAC_W = 16;

    // Configuration register indexes
    localparam logic [1:0] REG_MOUNT_ANGLE     = 2'd0;
    localparam logic [1:0] REG_ANGLE_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_GROUND_ROWS     = 2'd2;
    localparam logic [1:0] REG_COLUMN_COUNT    = 2'd3;

    // Label codes
    localparam logic [1:0] LBL_NOT_GROUND = 2'd0;
    localparam logic [1:0] LBL_GROUND     = 2'd1;
    localparam logic [1:0] LBL_NO_DATA    = 2'd2;

    typedef struct packed {
        logic signed [15:0] mount_angle;
        logic [14:0]        angle_threshold;
        logic [3:0]         ground_rows;
        logic [12:0]        column_count;
    } cfg_t;

    typedef struct packed {
        logic [11:0] column;
        logic [3:0]  row;
        logic [1:0]  label;
        logic        last;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic square;
        logic radicand;
        logic root_step;
        logic rot_init;
        logic rot_step;
        logic decide;
        logic emit;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic ring_zero;
        logic pair_valid;
        logic root_last;
        logic rot_last;
        logic out_empty;
    } sts_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    // atan(2^-i) in Q.20 radians
    function automatic logic [19:0] atan_q20(input logic [4:0] idx);
        logic [19:0] v;
        unique case (idx)
            5'd0:    v = 20'd823550;
            5'd1:    v = 20'd486170;
            5'd2:    v = 20'd256879;
            5'd3:    v = 20'd130396;
            5'd4:    v = 20'd65451;
            5'd5:    v = 20'd32757;
            5'd6:    v = 20'd16383;
            5'd7:    v = 20'd8192;
            5'd8:    v = 20'd4096;
            5'd9:    v = 20'd2048;
            5'd10:   v = 20'd1024;
            5'd11:   v = 20'd512;
            5'd12:   v = 20'd256;
            5'd13:   v = 20'd128;
            5'd14:   v = 20'd64;
            5'd15:   v = 20'd32;
            5'd16:   v = 20'd16;
            5'd17:   v = 20'd8;
            5'd18:   v = 20'd4;
            5'd19:   v = 20'd2;
            5'd20:   v = 20'd1;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

    // One restoring square-root step on the next radicand bit pair
    function automatic sqrt_t sqrt_step(input sqrt_t cur, input logic [1:0] bits);
        sqrt_t             res;
        logic [REM_W-1:0]  sh;
        logic [REM_W-1:0]  trial;
        sh    = {cur.rem[REM_W-3:0], bits};
        trial = {cur.root, 2'b01};
        if (sh >= trial)
        begin
            res.rem  = sh - trial;
            res.root = {cur.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            res.rem  = sh;
            res.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

[hw/rtl/lagl_ctrl.sv]
// Sequencer of the ground labeler: steps the datapath through one point.
module lagl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  lagl_pkg::sts_t sts,
    output lagl_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SQ     = 4'd1;
    localparam logic [3:0] S_SUM    = 4'd2;
    localparam logic [3:0] S_SQRT   = 4'd3;
    localparam logic [3:0] S_CINIT  = 4'd4;
    localparam logic [3:0] S_CORDIC = 4'd5;
    localparam logic [3:0] S_FINAL  = 4'd6;
    localparam logic [3:0] S_EMIT   = 4'd7;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.ring_zero)
                        state_next = S_IDLE;
                    else if (!sts.pair_valid)
                        state_next = S_EMIT;
                    else
                        state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.square = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.radicand = 1'b1;
                state_next   = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.root_step = 1'b1;
                if (sts.root_last)
                    state_next = S_CINIT;
            end
            S_CINIT:
            begin
                cmd.rot_init = 1'b1;
                state_next   = S_CORDIC;
            end
            S_CORDIC:
            begin
                cmd.rot_step = 1'b1;
                if (sts.rot_last)
                    state_next = S_FINAL;
            end
            S_FINAL:
            begin
                cmd.decide = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_empty)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // At most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command active");

endmodule

[hw/rtl/lagl_datapath.sv]
// Ground labeler datapath: differences, square root, CORDIC, labels, result buffer.
module lagl_datapath #(
    parameter int CORDIC_STEPS = lagl_pkg::CORDIC_STEPS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lagl_pkg::cfg_t        cfg,
    input  logic signed [17:0]    in_x,
    input  logic signed [17:0]    in_y,
    input  logic signed [17:0]    in_z,
    input  logic                  in_pvalid,
    input  lagl_pkg::cmd_t        cmd,
    output lagl_pkg::sts_t        sts,
    output lagl_pkg::out_item_t   out_item,
    output logic                  out_valid,
    input  logic                  out_ready
);

    localparam int ITER_N  = (CORDIC_STEPS > lagl_pkg::SQRT_CYC) ?
                             CORDIC_STEPS : lagl_pkg::SQRT_CYC;
    localparam int ITER_W  = $clog2(ITER_N);
    localparam int TOP_LIM = (lagl_pkg::MAX_RINGS - 1 > 15) ? 15 : lagl_pkg::MAX_RINGS - 1;
    localparam int XY_W    = lagl_pkg::XY_W;
    localparam int ANG_W   = lagl_pkg::ANG_W;

    // Column state
    logic signed [17:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic               prev_valid_reg;
    logic [3:0]         ring_reg;
    logic [11:0]        col_reg;
    logic               lower_reg;

    // Working registers of one pair
    logic [17:0]                      ax_reg, ay_reg;
    logic signed [18:0]               dz_reg;
    logic                             pair_valid_reg;
    logic [35:0]                      sqx_reg, sqy_reg;
    logic [lagl_pkg::RAD_W-1:0]       rad_reg;
    lagl_pkg::sqrt_t                  sq_reg;
    logic signed [XY_W-1:0]           x_reg, y_reg;
    logic signed [ANG_W-1:0]          z_reg;
    logic                             zero_reg;
    logic                             pass_reg;
    logic [ITER_W-1:0]                iter_reg;

    // Result buffer
    lagl_pkg::out_item_t ob0_reg, ob1_reg;
    logic [1:0]          ob_cnt_reg;

    // Differences against the stored point
    logic signed [18:0] dx, dy, dz;
    logic [18:0]        adx, ady;
    logic               pair_valid;

    assign dx  = {in_x[17], in_x} - {prev_x_reg[17], prev_x_reg};
    assign dy  = {in_y[17], in_y} - {prev_y_reg[17], prev_y_reg};
    assign dz  = {in_z[17], in_z} - {prev_z_reg[17], prev_z_reg};
    assign adx = dx[18] ? 19'(-dx) : 19'(dx);
    assign ady = dy[18] ? 19'(-dy) : 19'(dy);
    assign pair_valid = prev_valid_reg & in_pvalid;

    // Two square-root steps per cycle
    lagl_pkg::sqrt_t sq_mid, sq_next;
    assign sq_mid  = lagl_pkg::sqrt_step(sq_reg, rad_reg[lagl_pkg::RAD_W-1 -: 2]);
    assign sq_next = lagl_pkg::sqrt_step(sq_mid, rad_reg[lagl_pkg::RAD_W-3 -: 2]);

    // CORDIC vectoring step
    logic signed [XY_W-1:0]  xs, ys, x_next, y_next;
    logic signed [ANG_W-1:0] atan_v, z_next;

    assign xs     = x_reg >>> iter_reg;
    assign ys     = y_reg >>> iter_reg;
    assign atan_v = signed'({3'b000, lagl_pkg::atan_q20(5'(iter_reg))});

    always_comb
    begin
        if (!y_reg[XY_W-1])
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + atan_v;
        end
        else
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - atan_v;
        end
    end

    // Rounding to Q2.13 and threshold test
    logic signed [ANG_W-1:0] z_rnd;
    logic signed [15:0]      angle;
    logic signed [16:0]      dev;
    logic [16:0]             adev;
    logic                    pass_next;

    assign z_rnd     = z_reg + ANG_W'(64);
    assign angle     = zero_reg ? 16'sd0 : z_rnd[ANG_W-1:7];
    assign dev       = {angle[15], angle} - {cfg.mount_angle[15], cfg.mount_angle};
    assign adev      = dev[16] ? 17'(-dev) : 17'(dev);
    assign pass_next = (adev <= {2'b00, cfg.angle_threshold});

    // Top ring and column wrap
    logic [3:0]  top_row;
    logic        top_hit;
    logic [12:0] cc_eff, col_inc;
    logic [11:0] col_next;

    always_comb
    begin
        priority if (cfg.ground_rows == 4'd0)
            top_row = 4'd1;
        else if (cfg.ground_rows > 4'(TOP_LIM))
            top_row = 4'(TOP_LIM);
        else
            top_row = cfg.ground_rows;
    end

    assign top_hit  = (ring_reg >= top_row);
    assign cc_eff   = (cfg.column_count == 13'd0 || cfg.column_count > 13'd4096) ?
                      13'd4096 : cfg.column_count;
    assign col_inc  = {1'b0, col_reg} + 13'd1;
    assign col_next = (col_inc >= cc_eff) ? 12'd0 : col_inc[11:0];

    // Labels of the finished rows
    lagl_pkg::out_item_t item0, item1;

    always_comb
    begin
        item0.column = col_reg;
        item0.row    = ring_reg - 4'd1;
        item0.last   = 1'b0;
        priority if (!pair_valid_reg)
            item0.label = lagl_pkg::LBL_NO_DATA;
        else if (pass_reg || lower_reg)
            item0.label = lagl_pkg::LBL_GROUND;
        else
            item0.label = lagl_pkg::LBL_NOT_GROUND;
        item1.column = col_reg;
        item1.row    = ring_reg;
        item1.label  = pass_reg ? lagl_pkg::LBL_GROUND : lagl_pkg::LBL_NOT_GROUND;
        item1.last   = 1'b1;
    end

    logic pop;
    assign pop       = out_valid & out_ready;
    assign out_valid = (ob_cnt_reg != 2'd0);
    assign out_item  = ob0_reg;

    assign sts.ring_zero  = (ring_reg == 4'd0);
    assign sts.pair_valid = pair_valid;
    assign sts.root_last  = (iter_reg == ITER_W'(lagl_pkg::SQRT_CYC - 1));
    assign sts.rot_last   = (iter_reg == ITER_W'(CORDIC_STEPS - 1));
    assign sts.out_empty  = (ob_cnt_reg == 2'd0);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= 1'b0;
            ring_reg       <= 4'd0;
            col_reg        <= 12'd0;
            lower_reg      <= 1'b0;
            iter_reg       <= '0;
            ob_cnt_reg     <= 2'd0;
        end
        else
        begin
            if (cmd.load)
            begin
                prev_valid_reg <= in_pvalid;
                if (ring_reg == 4'd0)
                begin
                    ring_reg  <= 4'd1;
                    lower_reg <= 1'b0;
                end
            end
            if (cmd.radicand || cmd.rot_init)
                iter_reg <= '0;
            else if (cmd.root_step || cmd.rot_step)
                iter_reg <= iter_reg + ITER_W'(1);
            if (cmd.emit)
            begin
                if (top_hit)
                begin
                    ring_reg   <= 4'd0;
                    lower_reg  <= 1'b0;
                    col_reg    <= col_next;
                    ob_cnt_reg <= 2'd2;
                end
                else
                begin
                    ring_reg   <= ring_reg + 4'd1;
                    lower_reg  <= pass_reg;
                    ob_cnt_reg <= 2'd1;
                end
            end
            else if (pop)
            begin
                ob_cnt_reg <= ob_cnt_reg - 2'd1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            prev_x_reg     <= in_x;
            prev_y_reg     <= in_y;
            prev_z_reg     <= in_z;
            ax_reg         <= adx[17:0];
            ay_reg         <= ady[17:0];
            dz_reg         <= dz;
            pair_valid_reg <= pair_valid;
            pass_reg       <= 1'b0;
        end
        if (cmd.square)
        begin
            sqx_reg <= ax_reg * ax_reg;
            sqy_reg <= ay_reg * ay_reg;
        end
        if (cmd.radicand)
        begin
            rad_reg <= lagl_pkg::RAD_W'({1'b0, sqx_reg} + {1'b0, sqy_reg});
            sq_reg  <= '0;
        end
        if (cmd.root_step)
        begin
            rad_reg <= {rad_reg[lagl_pkg::RAD_W-5:0], 4'b0000};
            sq_reg  <= sq_next;
        end
        if (cmd.rot_init)
        begin
            x_reg    <= signed'({2'b00, sq_reg.root, {lagl_pkg::FRAC_W{1'b0}}});
            y_reg    <= signed'({{3{dz_reg[18]}}, dz_reg, {lagl_pkg::FRAC_W{1'b0}}});
            z_reg    <= '0;
            zero_reg <= (sq_reg.root == '0) && (dz_reg == 19'sd0);
        end
        if (cmd.rot_step)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (cmd.decide)
            pass_reg <= pass_next;
        if (cmd.emit)
        begin
            ob0_reg <= item0;
            ob1_reg <= item1;
        end
        else if (pop)
        begin
            ob0_reg <= ob1_reg;
        end
    end

    a_emit_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> ob_cnt_reg == 2'd0)
        else $error("results written over a non-empty buffer");

    a_close_column: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && top_hit |=> ring_reg == 4'd0 && !lower_reg && ob_cnt_reg == 2'd2)
        else $error("column not closed after top ring");

    a_ring_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load && ring_reg == 4'd0 |=> ring_reg == 4'd1 && ob_cnt_reg != 2'd3)
        else $error("ring zero did not advance the ring counter");

endmodule

[hw/rtl/lidar_angle_ground_labeler_core.sv]
// Top level of the angle-based lidar ground labeler: ports, config registers, packing.
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tdata: x_mm, y_mm, z_mm; tuser: point_valid
//  m_axis    out  m_axis_tvalid/tready    tdata: column, row, label; tlast: last_of_column
//  cfg       in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
//  A ring 0 point is only stored. A pair with a missing point goes straight to the
//  label write. A valid pair runs the squares, the radicand sum, the two-bit-per-cycle
//  square root and the one-step-per-cycle CORDIC loop of CORDIC_STEPS steps first.
//  Results sit in a two-entry buffer; a new point is taken while it drains, and
//  the label write of the next pair waits until the buffer is empty.
//  Reset clears the column state and loads the register defaults.
module lidar_angle_ground_labeler_core #(
    parameter int CORDIC_STEPS = lagl_pkg::CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // x_mm[17:0], y_mm[35:18], z_mm[53:36], zero
    input  logic        s_axis_tuser,   // point_valid
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // column[11:0], row[15:12], label[17:16], zero
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    lagl_pkg::cfg_t      cfg_reg;
    lagl_pkg::cmd_t      cmd;
    lagl_pkg::sts_t      sts;
    lagl_pkg::out_item_t out_item;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mount_angle     <= 16'sd0;
            cfg_reg.angle_threshold <= 15'd1430;
            cfg_reg.ground_rows     <= 4'd7;
            cfg_reg.column_count    <= 13'd1800;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lagl_pkg::REG_MOUNT_ANGLE:     cfg_reg.mount_angle     <= signed'(cfg_data);
                lagl_pkg::REG_ANGLE_THRESHOLD: cfg_reg.angle_threshold <= cfg_data[14:0];
                lagl_pkg::REG_GROUND_ROWS:     cfg_reg.ground_rows     <= cfg_data[3:0];
                lagl_pkg::REG_COLUMN_COUNT:    cfg_reg.column_count    <= cfg_data[12:0];
                default:                       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    lagl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lagl_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_x      (signed'(s_axis_tdata[17:0])),
        .in_y      (signed'(s_axis_tdata[35:18])),
        .in_z      (signed'(s_axis_tdata[53:36])),
        .in_pvalid (s_axis_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .out_item  (out_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

    // Output transaction packing
    assign m_axis_tdata = {6'd0, out_item.label, out_item.row, out_item.column};
    assign m_axis_tlast = out_item.last;

endmodule

[tb/sv/lidar_angle_ground_labeler_core_test.sv]
// Self-checking testbench of the lidar angle ground labeler core with a built-in label predictor.
`timescale 1ns / 100ps

module lidar_angle_ground_labeler_core_test;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 48;
    localparam int PHASE_ITEMS    = 312;
    localparam int ATAN_STEPS     = lagl_pkg::CORDIC_STEPS_DEF;

    typedef struct packed {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] z;
        logic               valid;
    } point_t;

    // DUT ports
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;   // x_mm[17:0], y_mm[35:18], z_mm[53:36], zero
    logic        s_axis_tuser  = 1'b0; // point_valid
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // column[11:0], row[15:12], label[17:16], zero
    logic        m_axis_tlast;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index     = '0;
    logic [15:0] cfg_data      = '0;

    // Predictor copy of the registers (reset values)
    logic signed [15:0] cfg_mount = '0;
    logic [14:0]        cfg_thr   = 15'd1430;
    logic [3:0]         cfg_rows  = 4'd7;
    logic [12:0]        cfg_cols  = 13'd1800;

    // Predictor copy of the column state
    logic signed [17:0] last_x       = '0;
    logic signed [17:0] last_y       = '0;
    logic signed [17:0] last_z       = '0;
    logic               last_valid   = 1'b0;
    logic [3:0]         ring_idx     = '0;
    logic [11:0]        col_idx      = '0;
    logic               below_ground = 1'b0;

    // atan(2^-i) in Q.20 radians
    longint atan_q20_tab [24] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0
    };

    lagl_pkg::out_item_t pending_labels [$];
    int                  mismatch_count = 0;
    int                  burst_left     = 0;
    int                  idle_cycles    = 0;
    int                  rx_tick        = 0;
    int                  rx_mode        = 0;

    lidar_angle_ground_labeler_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // Floor square root, bit by bit from the top
    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        int              b;
        r = 0;
        for (b = 19; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // Vectoring CORDIC: atan2(dz, h) in Q2.13 radians
    function automatic longint elevation_q13(input longint dz, input longint h);
        longint xr;
        longint yr;
        longint acc;
        longint xs;
        longint ys;
        int     i;
        if (dz == 0 && h == 0)
            return 0;
        xr  = h * 65536;
        yr  = dz * 65536;
        acc = 0;
        for (i = 0; i < ATAN_STEPS; i++)
        begin
            xs = xr >>> i;
            ys = yr >>> i;
            if (yr >= 0)
            begin
                xr  = xr + ys;
                yr  = yr - xs;
                acc = acc + atan_q20_tab[i];
            end
            else
            begin
                xr  = xr - ys;
                yr  = yr + xs;
                acc = acc - atan_q20_tab[i];
            end
        end
        return (acc + 64) >>> 7;
    endfunction

    function automatic int clamp18(input longint v);
        if (v > 131071)
            return 131071;
        if (v < -131072)
            return -131072;
        return int'(v);
    endfunction

    // Work out the labels caused by one accepted point and queue them
    task automatic label_point(input point_t p);
        int                  top;
        int                  cols;
        longint              dx;
        longint              dy;
        longint              dz;
        longint              h;
        longint              dev;
        logic                pair_ok;
        logic                pass;
        lagl_pkg::out_item_t item;
        top = cfg_rows;
        if (top == 0)
            top = 1;
        if (top > lagl_pkg::MAX_RINGS - 1)
            top = lagl_pkg::MAX_RINGS - 1;
        if (ring_idx == 0)
        begin
            below_ground = 1'b0;
            ring_idx     = 4'd1;
        end
        else
        begin
            pair_ok = last_valid && p.valid;
            pass    = 1'b0;
            if (pair_ok)
            begin
                dx   = longint'(p.x) - longint'(last_x);
                dy   = longint'(p.y) - longint'(last_y);
                dz   = longint'(p.z) - longint'(last_z);
                h    = longint'(root_floor(dx * dx + dy * dy));
                dev  = elevation_q13(dz, h) - longint'(cfg_mount);
                if (dev < 0)
                    dev = -dev;
                pass = (dev <= longint'(cfg_thr));
            end
            // lower row is final now
            item.column = col_idx;
            item.row    = ring_idx - 4'd1;
            item.label  = !pair_ok ? lagl_pkg::LBL_NO_DATA
                        : ((pass || below_ground) ? lagl_pkg::LBL_GROUND
                                                  : lagl_pkg::LBL_NOT_GROUND);
            item.last   = 1'b0;
            pending_labels.push_back(item);
            if (ring_idx >= top)
            begin
                // top row closes the column
                item.row   = ring_idx;
                item.label = pass ? lagl_pkg::LBL_GROUND : lagl_pkg::LBL_NOT_GROUND;
                item.last  = 1'b1;
                pending_labels.push_back(item);
                ring_idx     = '0;
                below_ground = 1'b0;
                cols         = cfg_cols;
                if (cols == 0 || cols > 4096)
                    cols = 4096;
                if (int'(col_idx) + 1 >= cols)
                    col_idx = '0;
                else
                    col_idx = col_idx + 12'd1;
            end
            else
            begin
                below_ground = pass;
                ring_idx     = ring_idx + 4'd1;
            end
        end
        last_x     = p.x;
        last_y     = p.y;
        last_z     = p.z;
        last_valid = p.valid;
    endtask

    // Send one point in bursts with random gaps; valid stays up for the next transaction
    task automatic send_point(input int x, input int y, input int z, input bit v);
        point_t p;
        int     gap;
        p.x     = x[17:0];
        p.y     = y[17:0];
        p.z     = z[17:0];
        p.valid = v;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, p.z, p.y, p.x};
        s_axis_tuser  <= p.valid;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        label_point(p);
        burst_left--;
    endtask

    // Stop sending and wait until every label has come out, plus the block's latency
    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        while (pending_labels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[15:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            lagl_pkg::REG_MOUNT_ANGLE:     cfg_mount = val[15:0];
            lagl_pkg::REG_ANGLE_THRESHOLD: cfg_thr   = val[14:0];
            lagl_pkg::REG_GROUND_ROWS:     cfg_rows  = val[3:0];
            default:                       cfg_cols  = val[12:0];
        endcase
    endtask

    // Write all four registers; only called while the block is idle
    task automatic configure(input int mount, input int thr, input int rows, input int cols);
        write_reg(lagl_pkg::REG_MOUNT_ANGLE, mount);
        write_reg(lagl_pkg::REG_ANGLE_THRESHOLD, thr);
        write_reg(lagl_pkg::REG_GROUND_ROWS, rows);
        write_reg(lagl_pkg::REG_COLUMN_COUNT, cols);
        cfg_valid <= 1'b0;
    endtask

    // One column at reset settings: flat ground, a missing return, a steep step
    task automatic test_default_column;
        send_point(2000, 0, -1700, 1);
        send_point(2600, 100, -1690, 1);
        send_point(3400, 200, -1700, 1);
        send_point(4500, 0, -1700, 0);
        send_point(6000, 0, -1700, 1);
        send_point(8000, 0, -1650, 1);
        send_point(8200, 0, 3000, 1);
        send_point(10000, 0, 3100, 1);
    endtask

    // Two-ring columns with coordinate extremes, coincident and vertical pairs
    task automatic test_field_extremes;
        wait_drained;
        configure(0, 1430, 1, 2);
        send_point(0, 0, 0, 1);
        send_point(0, 0, 0, 1);
        send_point(131071, 131071, 131071, 1);
        send_point(-131072, -131072, -131072, 1);
        send_point(0, 0, -131072, 1);
        send_point(0, 0, 131071, 1);
        send_point(-131072, 131071, 0, 1);
        send_point(131071, -131072, 0, 0);
        send_point(5, 5, 5, 0);
        send_point(5, 5, 5, 1);
    endtask

    // Top ring clamping, column count extremes, ring counter above a lowered top ring
    task automatic test_top_ring_limits;
        wait_drained;
        configure(-25736, 0, 0, 1);
        send_point(1000, 0, 0, 1);
        send_point(2000, 0, 0, 1);
        wait_drained;
        configure(25736, 25736, 15, 0);
        send_point(1500, 300, -1500, 1);
        send_point(1800, 350, -1480, 1);
        send_point(2300, 420, -1500, 1);
        send_point(3100, 560, -900, 1);
        send_point(4200, 700, -1490, 1);
        wait_drained;
        configure(0, 1430, 2, 4096);
        send_point(5600, 900, -1500, 1);
    endtask

    // Scan-like columns with random content, mixed with noise, over several settings
    task automatic test_random_scans;
        int     phase;
        int     n;
        int     ux;
        int     uy;
        int     base_z;
        int     ma;
        int     th;
        int     gr;
        int     cc;
        longint h;
        longint zz;
        ux     = 1024;
        uy     = 0;
        base_z = -1700;
        for (phase = 0; phase < 6; phase++)
        begin
            wait_drained;
            case (phase)
                0:
                begin
                    ma = int'($urandom_range(0, 1200)) - 600;
                    th = $urandom_range(200, 2000);
                    gr = $urandom_range(1, 15);
                    cc = $urandom_range(1, 12);
                end
                1:
                begin
                    ma = int'($urandom_range(0, 6000)) - 3000;
                    th = $urandom_range(0, 4000);
                    gr = $urandom_range(1, 4);
                    cc = $urandom_range(1, 4096);
                end
                2, 5:
                begin
                    ma = $urandom;
                    th = $urandom;
                    gr = $urandom;
                    cc = $urandom;
                end
                3:
                begin
                    ma = ($urandom_range(0, 1) == 0) ? 25736 : -25736;
                    th = 25736;
                    gr = 15;
                    cc = 4096;
                end
                default:
                begin
                    ma = 0;
                    th = 1430;
                    gr = 7;
                    cc = 3;
                end
            endcase
            configure(ma, th, gr, cc);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold off once until the block has emptied
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    wait_drained;
                if (ring_idx == 0)
                begin
                    ux     = int'($urandom_range(0, 2048)) - 1024;
                    uy     = int'($urandom_range(0, 2048)) - 1024;
                    base_z = -int'($urandom_range(1000, 2500));
                end
                if ($urandom_range(0, 99) < 12)
                begin
                    send_point(int'($urandom), int'($urandom), int'($urandom),
                               1'($urandom_range(0, 1)));
                end
                else
                begin
                    h  = 1500 + longint'(ring_idx) * ring_idx * 250 + $urandom_range(0, 300);
                    zz = base_z + (h * longint'(cfg_mount)) / 8192
                         + int'($urandom_range(0, 60)) - 30;
                    if ($urandom_range(0, 99) < 15)
                        zz = zz + $urandom_range(300, 4000);
                    send_point(clamp18(h * ux / 1024), clamp18(h * uy / 1024), clamp18(zz),
                               $urandom_range(0, 99) < 92);
                end
            end
        end
    endtask

    // Receiver ready pattern: free running, random, periodic or long stalls
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 64 == 0)
            rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= (rx_tick % 9 >= 4);
            default: m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Compare each output transaction with the oldest queued label
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_labels.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected label: column %0d row %0d label %0d last %0b",
                         $time, m_axis_tdata[11:0], m_axis_tdata[15:12],
                         m_axis_tdata[17:16], m_axis_tlast);
            end
            else
            begin
                if (m_axis_tdata[11:0] !== pending_labels[0].column)
                begin
                    mismatch_count++;
                    $display("%0t: column expected %0d actual %0d", $time,
                             pending_labels[0].column, m_axis_tdata[11:0]);
                end
                if (m_axis_tdata[15:12] !== pending_labels[0].row)
                begin
                    mismatch_count++;
                    $display("%0t: row expected %0d actual %0d", $time,
                             pending_labels[0].row, m_axis_tdata[15:12]);
                end
                if (m_axis_tdata[17:16] !== pending_labels[0].label)
                begin
                    mismatch_count++;
                    $display("%0t: label expected %0d actual %0d (column %0d row %0d)",
                             $time, pending_labels[0].label, m_axis_tdata[17:16],
                             pending_labels[0].column, pending_labels[0].row);
                end
                if (m_axis_tlast !== pending_labels[0].last)
                begin
                    mismatch_count++;
                    $display("%0t: last_of_column expected %0b actual %0b", $time,
                             pending_labels[0].last, m_axis_tlast);
                end
                void'(pending_labels.pop_front());
            end
        end
    end

    // Watchdog: cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_default_column;
        test_field_extremes;
        test_top_ring_limits;
        test_random_scans;
        wait_drained;
        if (mismatch_count == 0 && pending_labels.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
